/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the PS/2 host link controller blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define PS2HL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition is followed by a property in the next cycle.
`define PS2HL_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

/* hdl/ps2hl_pkg.sv */
// ----------------------------------------------------------------------------
// PS/2 host link package
// Types, constants and helpers shared by the PS/2 host link controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ps2hl_pkg;

  localparam int FIFO_DEPTH_DEFAULT = 4;

  localparam logic [15:0] GAP_MAX          = 16'hFFFF;
  localparam logic [27:0] ELAPSED_MAX      = 28'h0FFF_FFFF;
  localparam logic [10:0] RX_IDLE_BITS     = 11'h7FF;
  localparam logic [15:0] GAP_LIMIT_RST    = 16'd5000;
  localparam logic [15:0] HOLD_TICKS_RST   = 16'd600;
  localparam logic [27:0] TIMEOUT_RST      = 28'h0FFF_FFFF;

  localparam logic [1:0] CFG_GAP_LIMIT  = 2'd0;
  localparam logic [1:0] CFG_HOLD_TICKS = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_EDGE = 2'd1,
    ACT_SEND = 2'd2,
    ACT_POP  = 2'd3
  } action_t;

  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_RX   = 6'b000010,
    PH_REQ  = 6'b000100,
    PH_HOLD = 6'b001000,
    PH_TX   = 6'b010000,
    PH_ACK  = 6'b100000
  } phase_t;

  localparam logic [2:0] CODE_IDLE = 3'd0;
  localparam logic [2:0] CODE_RX   = 3'd1;
  localparam logic [2:0] CODE_REQ  = 3'd2;
  localparam logic [2:0] CODE_HOLD = 3'd3;
  localparam logic [2:0] CODE_TX   = 3'd4;
  localparam logic [2:0] CODE_ACK  = 3'd5;

  typedef struct packed {
    logic [15:0] gap_limit;
    logic [15:0] hold_ticks;
    logic [27:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       clk_drive_low;
    logic       data_drive_low;
    logic       rx_byte_valid;
    logic [2:0] rx_count;
    logic       rx_done;
    logic       tx_done;
    logic       byte_dropped;
    logic [2:0] link_phase;
  } link_res_t;

  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] code;
    code = CODE_IDLE;
    unique case (ph)
      PH_IDLE: code = CODE_IDLE;
      PH_RX:   code = CODE_RX;
      PH_REQ:  code = CODE_REQ;
      PH_HOLD: code = CODE_HOLD;
      PH_TX:   code = CODE_TX;
      PH_ACK:  code = CODE_ACK;
      default: code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* hdl/ps2hl_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2hl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/ps2hl_link.sv */
// ----------------------------------------------------------------------------
// PS/2 host link state
// Applies one event per cycle, when advance is set, to the receive, transmit and FIFO state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ps2hl_link #(
  parameter int FIFO_DEPTH = ps2hl_pkg::FIFO_DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ps2hl_pkg::cfg_t     cfg,
  input  wire logic                advance,
  input  wire ps2hl_pkg::action_t  act,
  input  wire logic                data_bit,
  input  wire logic [7:0]          cmd,
  output ps2hl_pkg::link_res_t     res,
  output logic [7:0]               pop_data
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  ps2hl_pkg::phase_t phase, phase_next;
  logic [10:0] rx_shift, rx_shift_next;
  logic [9:0]  tx_shift, tx_shift_next;
  logic [15:0] gap, gap_next;
  logic [27:0] elapsed, elapsed_next;
  logic [AW-1:0] head, head_next, tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic rx_done, rx_done_next, tx_done, tx_done_next;
  logic clk_drv, clk_drv_next, data_drv, data_drv_next;

  logic [10:0] rx_base, rx_new;
  logic [9:0]  tx_shifted;
  logic        wr_en, rd_en, dropped;
  logic [CW+2:0] count_ext;

  always_comb begin
    phase_next    = phase;
    rx_shift_next = rx_shift;
    tx_shift_next = tx_shift;
    gap_next      = gap;
    elapsed_next  = elapsed;
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    rx_done_next  = rx_done;
    tx_done_next  = tx_done;
    clk_drv_next  = clk_drv;
    data_drv_next = data_drv;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    dropped       = 1'b0;
    rx_base       = (gap > cfg.gap_limit) ? ps2hl_pkg::RX_IDLE_BITS : rx_shift;
    rx_new        = {data_bit, rx_base[10:1]};
    tx_shifted    = {1'b0, tx_shift[9:1]};
    if (advance) begin
      unique case (act)
        ps2hl_pkg::ACT_TICK: begin
          if (gap != ps2hl_pkg::GAP_MAX) begin
            gap_next = gap + 16'd1;
          end
          unique case (phase)
            ps2hl_pkg::PH_REQ: begin
              rx_done_next  = 1'b0;
              tx_done_next  = 1'b0;
              clk_drv_next  = 1'b1;
              data_drv_next = 1'b1;
              phase_next    = ps2hl_pkg::PH_HOLD;
              elapsed_next  = '0;
            end
            ps2hl_pkg::PH_HOLD: begin
              if (elapsed < {12'd0, cfg.hold_ticks}) begin
                elapsed_next = elapsed + 28'd1;
              end else begin
                clk_drv_next = 1'b0;
                phase_next   = ps2hl_pkg::PH_TX;
                elapsed_next = '0;
              end
            end
            ps2hl_pkg::PH_TX: begin
              if (elapsed > cfg.timeout_ticks) begin
                data_drv_next = 1'b0;
                phase_next    = ps2hl_pkg::PH_IDLE;
              end else if (elapsed < ps2hl_pkg::ELAPSED_MAX) begin
                elapsed_next = elapsed + 28'd1;
              end
            end
            default: begin
            end
          endcase
        end
        ps2hl_pkg::ACT_EDGE: begin
          unique case (phase)
            ps2hl_pkg::PH_TX: begin
              data_drv_next = ~tx_shift[0];
              tx_shift_next = tx_shifted;
              if (tx_shifted == '0) begin
                phase_next = ps2hl_pkg::PH_ACK;
              end
            end
            ps2hl_pkg::PH_ACK: begin
              tx_done_next = 1'b1;
              phase_next   = ps2hl_pkg::PH_IDLE;
            end
            ps2hl_pkg::PH_REQ, ps2hl_pkg::PH_HOLD: begin
            end
            default: begin
              if (gap > cfg.gap_limit) begin
                rx_done_next = 1'b0;
              end
              gap_next      = '0;
              phase_next    = ps2hl_pkg::PH_RX;
              rx_shift_next = rx_new;
              if (!rx_new[0]) begin
                rx_done_next  = 1'b1;
                phase_next    = ps2hl_pkg::PH_IDLE;
                rx_shift_next = ps2hl_pkg::RX_IDLE_BITS;
                if (count != CW'(FIFO_DEPTH)) begin
                  wr_en      = 1'b1;
                  count_next = count + CW'(1);
                  tail_next  = (tail == AW'(FIFO_DEPTH - 1)) ? '0 : tail + AW'(1);
                end else begin
                  dropped = 1'b1;
                end
              end
            end
          endcase
        end
        ps2hl_pkg::ACT_SEND: begin
          tx_shift_next = {1'b1, ~^cmd, cmd};
          phase_next    = ps2hl_pkg::PH_REQ;
        end
        ps2hl_pkg::ACT_POP: begin
          if (count != '0) begin
            rd_en      = 1'b1;
            count_next = count - CW'(1);
            head_next  = (head == AW'(FIFO_DEPTH - 1)) ? '0 : head + AW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= ps2hl_pkg::PH_IDLE;
      rx_shift <= ps2hl_pkg::RX_IDLE_BITS;
      tx_shift <= '0;
      gap      <= '0;
      elapsed  <= '0;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      rx_done  <= 1'b0;
      tx_done  <= 1'b0;
      clk_drv  <= 1'b0;
      data_drv <= 1'b0;
    end else begin
      phase    <= phase_next;
      rx_shift <= rx_shift_next;
      tx_shift <= tx_shift_next;
      gap      <= gap_next;
      elapsed  <= elapsed_next;
      head     <= head_next;
      tail     <= tail_next;
      count    <= count_next;
      rx_done  <= rx_done_next;
      tx_done  <= tx_done_next;
      clk_drv  <= clk_drv_next;
      data_drv <= data_drv_next;
    end
  end

  ps2hl_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (tail),
    .wdata (rx_new[8:1]),
    .re    (rd_en),
    .raddr (head),
    .rdata (pop_data)
  );

  assign count_ext = {3'd0, count_next};

  always_comb begin
    res.clk_drive_low  = clk_drv_next;
    res.data_drive_low = data_drv_next;
    res.rx_byte_valid  = rd_en;
    res.rx_count       = count_ext[2:0];
    res.rx_done        = rx_done_next;
    res.tx_done        = tx_done_next;
    res.byte_dropped   = dropped;
    res.link_phase     = ps2hl_pkg::phase_code(phase_next);
  end

  `PS2HL_ASSERT(a_count_bound, count <= CW'(FIFO_DEPTH), "FIFO count above depth")
  `PS2HL_ASSERT(a_hold_drives, (phase != ps2hl_pkg::PH_HOLD) || (clk_drv && data_drv), "hold without both lines low")
  `PS2HL_ASSERT(a_ack_empty, (phase != ps2hl_pkg::PH_ACK) || (tx_shift == '0), "ack phase with bits left")
  `PS2HL_ASSERT(a_drop_full, !dropped || (count == CW'(FIFO_DEPTH)), "byte dropped with room left")
  `PS2HL_ASSERT_NEXT(a_empty_pop, advance && (act == ps2hl_pkg::ACT_POP) && (count == '0), $stable(count) && $stable(head), "pop of empty FIFO changed pointers")

endmodule

`default_nettype wire

/* hdl/ps2_host_link_controller_top.sv */
// ----------------------------------------------------------------------------
// PS/2 host link controller
// Host side of a PS/2 link: receive FIFO, request-to-send transmit, timers.
// ----------------------------------------------------------------------------
// Events enter on the s_axis channel, one per beat: tuser carries the action
// (tick, clock falling edge, send, pop), tdata the sampled data level and the
// command byte. Every event gives exactly one status beat on m_axis: line
// drives, popped byte, FIFO fill, sticky done flags, drop flag and phase.
// An accepted beat is held in the input register; the state update then
// loads the output register with its status beat. One beat is taken every
// cycle while m_axis does not stall; the state update is combinational
// logic, and the popped byte is read from the FIFO RAM in the same cycle
// that loads the output register.
// When m_axis stalls, the output register holds its beat and the input
// register keeps one more event, after which s_axis_tready drops.
// Reset clears the phase, timers, FIFO pointers, flags and line drives and loads
// the register defaults: gap limit 5000, hold 600, timeout 0x0FFFFFFF. The user must
// write registers via cfg_we, cfg_index and cfg_data only while idle; not enforced.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2_host_link_controller_top #(
  parameter int FIFO_DEPTH = ps2hl_pkg::FIFO_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [27:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: [0] data_line, [8:1] command, [15:9] zero.
  input  wire logic [15:0] s_axis_tdata,
  // tuser: [1:0] action.
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: [0] clk_drive_low, [1] data_drive_low, [9:2] rx_byte,
  // [10] rx_byte_valid, [13:11] rx_count, [14] rx_done, [15] tx_done,
  // [16] byte_dropped, [19:17] link_phase, [23:20] zero.
  output logic [23:0]      m_axis_tdata
);

  ps2hl_pkg::cfg_t      cfg;
  ps2hl_pkg::link_res_t res, res_q;
  ps2hl_pkg::action_t   act_q;

  logic       in_valid;
  logic       bit_q;
  logic [7:0] cmd_q;
  logic       advance;
  logic [7:0] pop_data;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gap_limit     <= ps2hl_pkg::GAP_LIMIT_RST;
      cfg.hold_ticks    <= ps2hl_pkg::HOLD_TICKS_RST;
      cfg.timeout_ticks <= ps2hl_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ps2hl_pkg::CFG_GAP_LIMIT:  cfg.gap_limit     <= cfg_data[15:0];
        ps2hl_pkg::CFG_HOLD_TICKS: cfg.hold_ticks    <= cfg_data[15:0];
        ps2hl_pkg::CFG_TIMEOUT:    cfg.timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      act_q <= ps2hl_pkg::action_t'(s_axis_tuser);
      bit_q <= s_axis_tdata[0];
      cmd_q <= s_axis_tdata[8:1];
    end
  end

  ps2hl_link #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_link (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .advance  (advance),
    .act      (act_q),
    .data_bit (bit_q),
    .cmd      (cmd_q),
    .res      (res),
    .pop_data (pop_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tdata = {4'd0,
                         res_q.link_phase,
                         res_q.byte_dropped,
                         res_q.tx_done,
                         res_q.rx_done,
                         res_q.rx_count,
                         res_q.rx_byte_valid,
                         res_q.rx_byte_valid ? pop_data : 8'h00,
                         res_q.data_drive_low,
                         res_q.clk_drive_low};

endmodule

`default_nettype wire
